/* rtl/gld_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gld_pkg
// Shared types and constants of the GIF LZW decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

   localparam int DEFAULT_MAX_CODE_BITS = 12;
   localparam int ADDR_BITS   = 12;
   localparam int CNT_BITS    = 13;
   localparam int STORE_DEPTH = 4096;
   localparam logic [3:0] MIN_SIZE_RESET = 4'd8;
   localparam logic [3:0] MIN_SIZE_LOW   = 4'd2;
   localparam logic [3:0] MIN_SIZE_HIGH  = 4'd8;

   localparam logic [2:0] STATUS_OK    = 3'd0;
   localparam logic [2:0] STATUS_END   = 3'd1;
   localparam logic [2:0] STATUS_BAD   = 3'd2;
   localparam logic [2:0] STATUS_CLEAR = 3'd3;
   localparam logic [2:0] STATUS_EMPTY = 3'd4;

   localparam logic REG_MIN_CODE_SIZE = 1'b0;

   typedef enum logic [2:0] {
      KIND_END     = 3'd0,
      KIND_CLEAR   = 3'd1,
      KIND_LITERAL = 3'd2,
      KIND_HIT     = 3'd3,
      KIND_NEW     = 3'd4,
      KIND_BAD     = 3'd5
   } kind_type;

   typedef struct packed {
      logic       load;
      logic       set_res;
      logic [2:0] status;
      logic       clear_stack;
      logic       do_clear;
      logic       clr_after;
      logic       k_from_code;
      logic       rd_first;
      logic       k_from_first;
      logic       k_from_prev;
      logic       add_entry;
      logic       walk_init;
      logic       walk_rd;
      logic       walk_step;
      logic       walk_root;
      logic       pop_start;
      logic       pop_finish;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     is_drain;
      logic     code_is_root;
      logic     stack_empty;
      logic     walk_more;
      logic     rsp_free;
   } stat_type;

endpackage
`default_nettype wire

/* rtl/gld_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gld_ctrl
// Sequencer that steps the datapath through one code or one drain.
// ----------------------------------------------------------------------------
module gld_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire gld_pkg::stat_type stat,
   output gld_pkg::cmd_type      cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DECIDE = 8'b0000_0010,
      ST_LOOKUP = 8'b0000_0100,
      ST_ADD    = 8'b0000_1000,
      ST_WCHK   = 8'b0001_0000,
      ST_WSTEP  = 8'b0010_0000,
      ST_POP    = 8'b0100_0000,
      ST_RESP   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE) && stat.rsp_free;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.set_res = 1'b1;
            cmd.status  = gld_pkg::STATUS_OK;
            if (stat.is_drain) begin
               if (stat.stack_empty) begin
                  cmd.status = gld_pkg::STATUS_EMPTY;
                  state_in   = ST_RESP;
               end else begin
                  cmd.pop_start = 1'b1;
                  state_in      = ST_POP;
               end
            end else begin
               cmd.clear_stack = 1'b1;
               case (stat.kind)
                  gld_pkg::KIND_END: begin
                     cmd.status = gld_pkg::STATUS_END;
                     state_in   = ST_RESP;
                  end
                  gld_pkg::KIND_CLEAR: begin
                     cmd.status   = gld_pkg::STATUS_CLEAR;
                     cmd.do_clear = 1'b1;
                     state_in     = ST_RESP;
                  end
                  gld_pkg::KIND_LITERAL: begin
                     cmd.k_from_code = 1'b1;
                     cmd.clr_after   = 1'b1;
                     cmd.walk_init   = 1'b1;
                     state_in        = ST_WCHK;
                  end
                  gld_pkg::KIND_HIT: begin
                     if (stat.code_is_root) begin
                        cmd.k_from_code = 1'b1;
                        state_in        = ST_ADD;
                     end else begin
                        cmd.rd_first = 1'b1;
                        state_in     = ST_LOOKUP;
                     end
                  end
                  gld_pkg::KIND_NEW: begin
                     cmd.k_from_prev = 1'b1;
                     state_in        = ST_ADD;
                  end
                  default: begin
                     cmd.status = gld_pkg::STATUS_BAD;
                     state_in   = ST_RESP;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            cmd.k_from_first = 1'b1;
            state_in         = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_entry = 1'b1;
            cmd.walk_init = 1'b1;
            state_in      = ST_WCHK;
         end
         ST_WCHK: begin
            if (stat.walk_more) begin
               cmd.walk_rd = 1'b1;
               state_in    = ST_WSTEP;
            end else begin
               cmd.walk_root = 1'b1;
               state_in      = ST_RESP;
            end
         end
         ST_WSTEP: begin
            cmd.walk_step = 1'b1;
            state_in      = ST_WCHK;
         end
         ST_POP: begin
            cmd.pop_finish = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/gld_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gld_datapath
// String tables, output stack, decoder state and the result register.
// ----------------------------------------------------------------------------
module gld_datapath #(
   parameter int MAX_CODE_BITS = gld_pkg::DEFAULT_MAX_CODE_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_opcode,
   input  wire logic [11:0]      req_code,
   input  wire logic             csr_we,
   input  wire logic             csr_sel0,
   input  wire logic [3:0]       csr_wval,
   output logic [3:0]            csr_min_size,
   input  wire gld_pkg::cmd_type cmd,
   output gld_pkg::stat_type     stat,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [7:0]            rsp_pixel,
   output logic                  rsp_last,
   output logic [12:0]           rsp_length,
   output logic [3:0]            rsp_width
);

   localparam int AB = gld_pkg::ADDR_BITS;
   localparam int CB = gld_pkg::CNT_BITS;
   localparam logic [CB-1:0] TABLE_CAP = CB'(1 << MAX_CODE_BITS);
   localparam logic [CB-1:0] WALK_LIMIT = CB'(gld_pkg::STORE_DEPTH - 1);
   localparam logic [3:0] WIDTH_MAX = 4'(MAX_CODE_BITS);

   logic [AB-1:0] prefix_mem [gld_pkg::STORE_DEPTH];
   logic [7:0]    suffix_mem [gld_pkg::STORE_DEPTH];
   logic [7:0]    first_mem  [gld_pkg::STORE_DEPTH];
   logic [7:0]    stack_mem  [gld_pkg::STORE_DEPTH];
   logic [AB-1:0] prefix_q;
   logic [7:0]    suffix_q, first_q, stack_q;

   logic [3:0]    mcs_ff, mcs_in;
   logic [CB-1:0] ts_ff, ts_in;
   logic [3:0]    cw_ff, cw_in;
   logic [AB-1:0] prev_ff, prev_in;
   logic [7:0]    pfirst_ff, pfirst_in;
   logic          after_ff, after_in;
   logic [CB-1:0] count_ff, count_in;
   logic          op_ff;
   logic [AB-1:0] code_ff;
   logic [7:0]    k_ff, k_in;
   logic [AB-1:0] c_ff, c_in;
   logic [CB-1:0] n_ff, n_in;
   logic [2:0]    rs_ff, rs_in;
   logic [7:0]    rp_ff, rp_in;
   logic          rl_ff, rl_in;
   logic [CB-1:0] rn_ff, rn_in;
   logic          ov_ff, ov_in;
   logic [2:0]    os_ff;
   logic [7:0]    op_pix_ff;
   logic          ol_ff;
   logic [CB-1:0] on_ff;
   logic [3:0]    ow_ff;

   logic [CB-1:0] roots, code_w, pop_cnt;
   logic [3:0]    wclamp;
   logic          stk_we;
   logic [AB-1:0] stk_waddr;
   logic [7:0]    stk_wdata;

   assign roots   = CB'(1) << mcs_ff;
   assign code_w  = {1'b0, code_ff};
   assign pop_cnt = count_ff - CB'(1);
   assign csr_min_size = mcs_ff;

   always_comb begin
      wclamp = csr_wval;
      if (csr_wval < gld_pkg::MIN_SIZE_LOW) begin
         wclamp = gld_pkg::MIN_SIZE_LOW;
      end else if (csr_wval > gld_pkg::MIN_SIZE_HIGH) begin
         wclamp = gld_pkg::MIN_SIZE_HIGH;
      end
   end

   always_comb begin
      if (code_w == roots + CB'(1)) begin
         stat.kind = gld_pkg::KIND_END;
      end else if (code_w == roots) begin
         stat.kind = gld_pkg::KIND_CLEAR;
      end else if (after_ff) begin
         stat.kind = (code_w < roots) ? gld_pkg::KIND_LITERAL : gld_pkg::KIND_BAD;
      end else if (code_w < ts_ff) begin
         stat.kind = gld_pkg::KIND_HIT;
      end else if (code_w == ts_ff && ts_ff < TABLE_CAP) begin
         stat.kind = gld_pkg::KIND_NEW;
      end else begin
         stat.kind = gld_pkg::KIND_BAD;
      end
      stat.is_drain     = op_ff;
      stat.code_is_root = code_w < roots;
      stat.stack_empty  = count_ff == '0;
      stat.walk_more    = ({1'b0, c_ff} >= roots) && (n_ff < WALK_LIMIT);
      stat.rsp_free     = !ov_ff || rsp_ready;
   end

   always_comb begin
      mcs_in    = mcs_ff;
      ts_in     = ts_ff;
      cw_in     = cw_ff;
      prev_in   = prev_ff;
      pfirst_in = pfirst_ff;
      after_in  = after_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      c_in      = c_ff;
      n_in      = n_ff;
      rs_in     = rs_ff;
      rp_in     = rp_ff;
      rl_in     = rl_ff;
      rn_in     = rn_ff;
      ov_in     = ov_ff && !rsp_ready;
      stk_we    = 1'b0;
      stk_waddr = n_ff[AB-1:0];
      stk_wdata = suffix_q;

      if (cmd.set_res) begin
         rs_in = cmd.status;
         rp_in = '0;
         rl_in = 1'b0;
         rn_in = '0;
      end
      if (cmd.clear_stack) count_in = '0;
      if (cmd.do_clear) begin
         ts_in    = roots + CB'(2);
         cw_in    = mcs_ff + 4'd1;
         prev_in  = '0;
         after_in = 1'b1;
      end
      if (cmd.clr_after) after_in = 1'b0;
      if (cmd.k_from_code) k_in = code_ff[7:0];
      if (cmd.k_from_first) k_in = first_q;
      if (cmd.k_from_prev) k_in = pfirst_ff;
      if (cmd.add_entry && ts_ff < TABLE_CAP) ts_in = ts_ff + CB'(1);
      if (cmd.walk_init) begin
         c_in = code_ff;
         n_in = '0;
      end
      if (cmd.walk_step) begin
         stk_we = 1'b1;
         c_in   = prefix_q;
         n_in   = n_ff + CB'(1);
      end
      if (cmd.walk_root) begin
         stk_we    = 1'b1;
         stk_wdata = c_ff[7:0];
         count_in  = n_ff + CB'(1);
         rn_in     = n_ff + CB'(1);
         prev_in   = code_ff;
         pfirst_in = k_ff;
         if (cw_ff < WIDTH_MAX && ts_ff == (CB'(1) << cw_ff)) cw_in = cw_ff + 4'd1;
      end
      if (cmd.pop_start) count_in = pop_cnt;
      if (cmd.pop_finish) begin
         rp_in = stack_q;
         rl_in = count_ff == '0;
         rn_in = count_ff;
      end
      if (cmd.rsp_load) ov_in = 1'b1;
      if (csr_we && csr_sel0 == gld_pkg::REG_MIN_CODE_SIZE) begin
         mcs_in   = wclamp;
         ts_in    = (CB'(1) << wclamp) + CB'(2);
         cw_in    = wclamp + 4'd1;
         prev_in  = '0;
         after_in = 1'b1;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_entry && ts_ff < TABLE_CAP) begin
         prefix_mem[ts_ff[AB-1:0]] <= prev_ff;
         suffix_mem[ts_ff[AB-1:0]] <= k_ff;
         first_mem[ts_ff[AB-1:0]]  <= pfirst_ff;
      end
      if (cmd.walk_rd) begin
         prefix_q <= prefix_mem[c_ff];
         suffix_q <= suffix_mem[c_ff];
      end
      if (cmd.rd_first) first_q <= first_mem[code_ff];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      if (cmd.pop_start) stack_q <= stack_mem[pop_cnt[AB-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcs_ff   <= gld_pkg::MIN_SIZE_RESET;
         ts_ff    <= (CB'(1) << gld_pkg::MIN_SIZE_RESET) + CB'(2);
         cw_ff    <= gld_pkg::MIN_SIZE_RESET + 4'd1;
         prev_ff  <= '0;
         after_ff <= 1'b1;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         mcs_ff   <= mcs_in;
         ts_ff    <= ts_in;
         cw_ff    <= cw_in;
         prev_ff  <= prev_in;
         after_ff <= after_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      pfirst_ff <= pfirst_in;
      k_ff      <= k_in;
      c_ff      <= c_in;
      n_ff      <= n_in;
      rs_ff     <= rs_in;
      rp_ff     <= rp_in;
      rl_ff     <= rl_in;
      rn_ff     <= rn_in;
      if (cmd.load) begin
         op_ff   <= req_opcode;
         code_ff <= req_code;
      end
      if (cmd.rsp_load) begin
         os_ff     <= rs_ff;
         op_pix_ff <= rp_ff;
         ol_ff     <= rl_ff;
         on_ff     <= rn_ff;
         ow_ff     <= cw_ff;
      end
   end

   assign rsp_valid  = ov_ff;
   assign rsp_status = os_ff;
   assign rsp_pixel  = op_pix_ff;
   assign rsp_last   = ol_ff;
   assign rsp_length = on_ff;
   assign rsp_width  = ow_ff;

endmodule
`default_nettype wire

/* rtl/gif_lzw_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// Variable-width GIF LZW decoder with a pop-one-per-beat output stack.
//
//   Channel  Direction  Carries
//   req_     in         tuser opcode, tdata code
//   rsp_     out        tuser status, tlast last_of_string, tdata results
//   csr_     in/out     min_code_size at byte address 0
//
// A drain pops the stack unless it is empty. An end, clear or bad code is
// answered without a table walk; any other code walks its prefix chain one
// table entry at a time, set by the single read port of the tables.
// Reset is synchronous; tables and stack hold no reset value.
// One beat is worked on at a time; a new beat is taken in the cycle its
// predecessor's result leaves or once the result register is empty.
// ----------------------------------------------------------------------------
module gif_lzw_decoder #(
   parameter int MAX_CODE_BITS = gld_pkg::DEFAULT_MAX_CODE_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // code[11:0]
   input  wire logic        req_tuser,   // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // pixel_index, string_length, next_code_width
   output logic [2:0]       rsp_tuser,   // status
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   gld_pkg::cmd_type  cmd;
   gld_pkg::stat_type stat;
   logic [3:0]  min_size;
   logic [7:0]  pixel;
   logic [12:0] length;
   logic [3:0]  width;
   logic        csr_we;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == gld_pkg::REG_MIN_CODE_SIZE) ?
                       {28'd0, min_size} : 32'd0;
   assign rsp_tdata  = {7'd0, width, length, pixel};

   gld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gld_datapath #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_opcode   (req_tuser),
      .req_code     (req_tdata[11:0]),
      .csr_we       (csr_we),
      .csr_sel0     (csr_paddr[2]),
      .csr_wval     (csr_pwdata[3:0]),
      .csr_min_size (min_size),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_status   (rsp_tuser),
      .rsp_pixel    (pixel),
      .rsp_last     (rsp_tlast),
      .rsp_length   (length),
      .rsp_width    (width)
   );

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GIF LZW decoder. Code and drain beats go in,
// mostly as well-formed code streams with random content; a local decoder
// model predicts every result beat and a checker compares them field by
// field. min_code_size is swept over in-range and out-of-range values, and
// one phase grows the string table through several code widths.
// ----------------------------------------------------------------------------
module tb_top;

   localparam bit OP_CODE  = 1'b0;
   localparam bit OP_DRAIN = 1'b1;
   localparam int TABLE_LIMIT = 4096;
   localparam int GROWTH_LIMIT = 512;
   localparam int STALL_LIMIT = 40000;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  pixel;
      logic        last;
      logic [12:0] length;
      logic [3:0]  width;
   } decode_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // code[11:0], zero fill
   logic        req_tuser = 1'b0; // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // pixel_index[7:0], string_length[20:8],
                                  // next_code_width[24:21], zero fill
   logic [2:0]  rsp_tuser;        // status
   logic        rsp_tlast;        // last_of_string
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   gif_lzw_decoder u_top (.*);

   initial forever #1 clock = ~clock;

   // Decoder model state.
   logic [11:0] prefix_of [TABLE_LIMIT];
   logic [7:0]  suffix_of [TABLE_LIMIT];
   logic [7:0]  head_of   [TABLE_LIMIT];
   logic [7:0]  pixel_stack [TABLE_LIMIT];
   int          stack_depth, table_next, code_bits, last_code, root_bits;
   bit          fresh;

   decode_result_type pending_results[$];
   int  error_count = 0;
   int  quiet_cycles = 0;
   bit  gaps_on = 1'b1;

   function automatic void restart_table();
      stack_depth = 0;
      table_next  = (1 << root_bits) + 2;
      code_bits   = root_bits + 1;
      last_code   = 0;
      fresh       = 1'b1;
   endfunction

   function automatic int head_index(int c);
      return (c < (1 << root_bits)) ? c : head_of[c];
   endfunction

   function automatic int expand_code(int c);
      int n = 0;
      while (c >= (1 << root_bits) && n < TABLE_LIMIT - 1) begin
         pixel_stack[n] = suffix_of[c];
         c = prefix_of[c];
         n++;
      end
      pixel_stack[n] = c[7:0];
      stack_depth = n + 1;
      return stack_depth;
   endfunction

   function automatic void grow_table(int k);
      prefix_of[table_next] = last_code[11:0];
      suffix_of[table_next] = k[7:0];
      head_of[table_next]   = 8'(head_index(last_code));
      table_next++;
   endfunction

   function automatic decode_result_type decode_beat(bit op, int c);
      decode_result_type r = '0;
      int clr = 1 << root_bits;
      int k;
      r.status = gld_pkg::STATUS_OK;
      if (op == OP_DRAIN) begin
         if (stack_depth == 0) r.status = gld_pkg::STATUS_EMPTY;
         else begin
            stack_depth--;
            r.pixel  = pixel_stack[stack_depth];
            r.last   = (stack_depth == 0);
            r.length = 13'(stack_depth);
         end
      end else begin
         stack_depth = 0;
         if (c == clr + 1) r.status = gld_pkg::STATUS_END;
         else if (c == clr) begin
            restart_table();
            r.status = gld_pkg::STATUS_CLEAR;
         end else if (fresh) begin
            if (c < clr) begin
               r.length = 13'(expand_code(c));
               last_code = c;
               fresh = 1'b0;
            end else r.status = gld_pkg::STATUS_BAD;
         end else if (c < table_next) begin
            k = head_index(c);
            r.length = 13'(expand_code(c));
            if (table_next < TABLE_LIMIT) grow_table(k);
            last_code = c;
         end else if (c == table_next && table_next < TABLE_LIMIT) begin
            grow_table(head_index(last_code));
            r.length = 13'(expand_code(c));
            last_code = c;
         end else r.status = gld_pkg::STATUS_BAD;
         if (r.status == gld_pkg::STATUS_OK && code_bits < gld_pkg::DEFAULT_MAX_CODE_BITS
             && table_next == (1 << code_bits))
            code_bits++;
      end
      r.width = 4'(code_bits);
      return r;
   endfunction

   task automatic send_beat(input bit op, input int c);
      decode_result_type predicted;
      if (gaps_on && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, c[11:0]};
      do @(posedge clock); while (!req_tready);
      predicted = decode_beat(op, int'(c[11:0]));
      pending_results = {pending_results, predicted};
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_results.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_min_size(input int v);
      settle();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'd0;
      csr_pwdata  <= ($urandom & 32'hFFFF_FFF0) | {28'd0, v[3:0]};
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      root_bits = (v < 2) ? 2 : (v > 8) ? 8 : v;
      restart_table();
   endtask

   // Well-formed codes, each followed by a random run of drains; some noise mixed in.
   task automatic send_stream(input int beats, input int noise_pct);
      int c, drains;
      repeat (beats) begin
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(3))
               0: c = $urandom_range(4095);
               1: c = 1 << root_bits;
               2: c = (1 << root_bits) + 1;
               default: c = table_next + $urandom_range(3, 1);
            endcase
         end else if (fresh) c = $urandom_range((1 << root_bits) - 1);
         else begin
            c = $urandom_range(table_next < TABLE_LIMIT ? table_next : TABLE_LIMIT - 1);
            if (c == (1 << root_bits) || c == (1 << root_bits) + 1) c = 0;
         end
         send_beat(OP_CODE, c);
         drains = $urandom_range(stack_depth + 1);
         repeat (drains) send_beat(OP_DRAIN, $urandom_range(4095));
      end
   endtask

   task automatic test_directed();
      send_beat(OP_DRAIN, 0);
      send_beat(OP_CODE, 257);
      send_beat(OP_CODE, 4095);
      send_beat(OP_CODE, 256);
      send_beat(OP_CODE, 255);
      send_beat(OP_DRAIN, 4095);
      send_beat(OP_DRAIN, 0);
      send_beat(OP_CODE, 258);
      repeat (3) send_beat(OP_DRAIN, 0);
      send_beat(OP_CODE, 0);
      send_beat(OP_CODE, 259);
      send_beat(OP_DRAIN, 0);
      send_beat(OP_CODE, 4095);
      send_beat(OP_CODE, 257);
      send_beat(OP_CODE, 0);
      send_beat(OP_CODE, 256);
      send_beat(OP_CODE, 2048);
   endtask

   task automatic test_size_sweep();
      int sizes[12] = '{2, 8, 0, 15, 3, 5, 7, 1, 9, 4, 6, 12};
      foreach (sizes[i]) begin
         write_min_size(sizes[i]);
         send_stream(12, 10);
      end
   endtask

   task automatic test_table_growth();
      int c;
      write_min_size(2);
      gaps_on = 1'b0;
      send_beat(OP_CODE, 1);
      while (table_next < GROWTH_LIMIT) begin
         c = ($urandom_range(3) == 0) ? table_next : $urandom_range(3);
         send_beat(OP_CODE, c);
      end
      gaps_on = 1'b1;
      repeat (10) begin
         send_beat(OP_CODE, $urandom_range(4095));
         repeat ($urandom_range(3)) send_beat(OP_DRAIN, 0);
      end
      send_beat(OP_CODE, 4);
      send_stream(5, 5);
   endtask

   task automatic test_random();
      write_min_size(8);
      send_stream(35, 10);
      write_min_size($urandom_range(7, 2));
      send_stream(35, 10);
   endtask

   initial begin
      root_bits = 8;
      restart_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_size_sweep();
      test_table_growth();
      test_random();
      settle();
      if (error_count == 0) $display("gif_lzw_decoder verification clean");
      else $display("gif_lzw_decoder verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !gaps_on || ($urandom_range(99) >= 22);
   end

   always @(posedge clock) begin
      decode_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no expectation waiting");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[7:0] !== want.pixel) begin
               $error("pixel_index: expected %0d, got %0d", want.pixel, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_string: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[20:8] !== want.length) begin
               $error("string_length: expected %0d, got %0d", want.length,
                      rsp_tdata[20:8]);
               error_count++;
            end
            if (rsp_tdata[24:21] !== want.width) begin
               $error("next_code_width: expected %0d, got %0d", want.width,
                      rsp_tdata[24:21]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (pending_results.size() == 0 && !req_tvalid))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("gif_lzw_decoder verification failed");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

endmodule
